// ===== rtl/apa_pkg.sv =====
// ----------------------------------------------------------------------------
// apa_pkg
// Shared widths and defaults for the polygon area and perimeter block.
// ----------------------------------------------------------------------------
package apa_pkg;

  // Payload widths of the stream fields
  localparam int unsigned CoordInW = 16;
  localparam int unsigned AreaW    = 40;
  localparam int unsigned LenW     = 27;
  localparam int unsigned TotalW   = 11;

  // Internal arithmetic widths
  localparam int unsigned OpW    = CoordInW + 1;  // coordinate difference
  localparam int unsigned ProdW  = 2 * OpW;       // multiplier product
  localparam int unsigned SqW    = ProdW;         // dx^2 + dy^2
  localparam int unsigned RootW  = SqW / 2;       // edge length
  localparam int unsigned CrossW = 43;            // shoelace accumulator

  // Defaults for the top-level parameters
  localparam int unsigned DefMaxVertices = 1024;
  localparam int unsigned DefCoordWidth  = 16;

endpackage

// ===== rtl/apa_stream_if.sv =====
// ----------------------------------------------------------------------------
// apa_stream_if
// Valid/ready channels carrying polygon vertices in and polygon results out.
// ----------------------------------------------------------------------------
interface apa_vertex_if;
  import apa_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [CoordInW-1:0] vertex_x;
  logic signed [CoordInW-1:0] vertex_y;
  logic                       last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

interface apa_result_if;
  import apa_pkg::*;

  logic              valid;
  logic              ready;
  logic [AreaW-1:0]  polygon_area;
  logic [LenW-1:0]   polygon_perimeter;
  logic [TotalW-1:0] vertex_total;
  logic              overflow_flag;

  modport source (output valid, output polygon_area, output polygon_perimeter,
                  output vertex_total, output overflow_flag, input ready);
  modport sink   (input valid, input polygon_area, input polygon_perimeter,
                  input vertex_total, input overflow_flag, output ready);
endinterface

// ===== rtl/polygon_area_perimeter_stream.sv =====
// ----------------------------------------------------------------------------
// polygon_area_perimeter_stream
// Shoelace area and floor-length perimeter of a streamed closed polygon.
// ----------------------------------------------------------------------------
// Vertices arrive one per request as signed Q8.8 x/y, the final one flagged
// by last_vertex; one result (area Q24.16, perimeter Q19.8, vertex count and
// overflow flag) follows each final vertex. Each edge runs through one shared
// 17x17 multiplier for four products (dx*dx, dy*dy and the two cross terms),
// then through a bit-serial square root unit that resolves one root bit per
// cycle and flags done in the cycle after its last root bit resolves. A
// polygon's first vertex is only stored; for every later vertex the edge to
// it runs through the multiplier steps, then the root is started and awaited.
// The final vertex also runs the closing edge, and the result register is
// loaded once it is free; a lone-vertex polygon runs only the closing edge.
// The next polygon can start while a result waits to be taken. Accumulators
// and the vertex count saturate and set overflow_flag.
module polygon_area_perimeter_stream #(
  parameter int unsigned MAX_VERTICES = apa_pkg::DefMaxVertices,
  parameter int unsigned COORD_WIDTH  = apa_pkg::DefCoordWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  apa_vertex_if.sink   vertex_i,
  apa_result_if.source result_o
);
  import apa_pkg::*;

  localparam int unsigned CoordW = (COORD_WIDTH > CoordInW) ? CoordInW : COORD_WIDTH;
  localparam int unsigned CntW   = $clog2(MAX_VERTICES + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_WAIT = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CoordW-1:0] first_x_q, first_y_q;
  logic [CoordW-1:0] prev_x_q, prev_y_q;
  logic [CoordW-1:0] cur_x_q, cur_y_q;
  logic              last_q;
  logic              close_q;
  logic [2:0]        step_q;

  logic signed [ProdW-1:0]  prod_q;
  logic [SqW-1:0]           sq_q;
  logic signed [ProdW-1:0]  term_q;
  logic signed [CrossW-1:0] cross_q;
  logic [LenW-1:0]          len_q;
  logic [CntW-1:0]          cnt_q;
  logic                     ovf_q;

  logic              out_valid_q;
  logic [AreaW-1:0]  area_q;
  logic [LenW-1:0]   perim_q;
  logic [TotalW-1:0] total_q;
  logic              oflag_q;

  logic                     accept;
  logic                     out_free;
  logic signed [OpW-1:0]    ax, ay, bx, by, dx, dy;
  logic signed [OpW-1:0]    mul_a, mul_b;
  logic signed [ProdW-1:0]  mul_p;
  logic signed [CrossW:0]   cross_sum;
  logic                     cross_ovf;
  logic signed [CrossW-1:0] cross_sat;
  logic [LenW:0]            len_sum;
  logic [CrossW-1:0]        mag;
  logic                     area_sat;
  logic                     root_start;
  logic                     root_done;
  logic [RootW-1:0]         root;

  function automatic logic signed [OpW-1:0] ext(input logic [CoordW-1:0] v);
    ext = {{(OpW - CoordW){v[CoordW-1]}}, v};
  endfunction

  assign accept   = vertex_i.valid && vertex_i.ready;
  assign out_free = !out_valid_q || result_o.ready;

  // Ordinary edge runs previous->current; closing edge runs current->first
  assign ax = close_q ? ext(cur_x_q)   : ext(prev_x_q);
  assign ay = close_q ? ext(cur_y_q)   : ext(prev_y_q);
  assign bx = close_q ? ext(first_x_q) : ext(cur_x_q);
  assign by = close_q ? ext(first_y_q) : ext(cur_y_q);
  assign dx = bx - ax;
  assign dy = by - ay;

  always_comb begin
    case (step_q[1:0])
      2'd0:    begin mul_a = dx; mul_b = dx; end
      2'd1:    begin mul_a = dy; mul_b = dy; end
      2'd2:    begin mul_a = ax; mul_b = by; end
      2'd3:    begin mul_a = bx; mul_b = ay; end
      default: begin mul_a = dx; mul_b = dx; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Saturating shoelace and length accumulation
  assign cross_sum = (CrossW + 1)'(cross_q) + (CrossW + 1)'(term_q);
  assign cross_ovf = (cross_sum[CrossW] != cross_sum[CrossW-1]);
  always_comb begin
    if (!cross_ovf) begin
      cross_sat = cross_sum[CrossW-1:0];
    end else if (cross_sum[CrossW]) begin
      cross_sat = {1'b1, {(CrossW - 1){1'b0}}};
    end else begin
      cross_sat = {1'b0, {(CrossW - 1){1'b1}}};
    end
  end
  assign len_sum  = (LenW + 1)'(len_q) + (LenW + 1)'(root);
  assign mag      = cross_q[CrossW-1] ? (CrossW'(0) - cross_q) : cross_q;
  assign area_sat = mag[CrossW-1] | mag[CrossW-2];

  assign root_start = (state_q == ST_ROOT);

  apa_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (sq_q),
    .done_o     (root_done),
    .root_o     (root)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && ((cnt_q != '0) || vertex_i.last_vertex)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (step_q == 3'd4) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (root_done) begin
          if (close_q) begin
            state_d = ST_EMIT;
          end else if (last_q) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      cross_q     <= '0;
      len_q       <= '0;
      close_q     <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            step_q  <= '0;
            close_q <= (cnt_q == '0);
            if (cnt_q >= CntW'(MAX_VERTICES)) begin
              cnt_q <= CntW'(MAX_VERTICES);
              ovf_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_MUL: begin
          step_q <= step_q + 1'b1;
        end
        ST_ROOT: begin
          cross_q <= cross_sat;
          if (cross_ovf) begin
            ovf_q <= 1'b1;
          end
        end
        ST_WAIT: begin
          if (root_done) begin
            if (len_sum[LenW]) begin
              len_q <= '1;
              ovf_q <= 1'b1;
            end else begin
              len_q <= len_sum[LenW-1:0];
            end
            if (!close_q && last_q) begin
              close_q <= 1'b1;
              step_q  <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            cnt_q       <= '0;
            ovf_q       <= 1'b0;
            cross_q     <= '0;
            len_q       <= '0;
            close_q     <= 1'b0;
          end
        end
        default: begin
          close_q <= 1'b0;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_x_q  <= vertex_i.vertex_x[CoordW-1:0];
      cur_y_q  <= vertex_i.vertex_y[CoordW-1:0];
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
      last_q   <= vertex_i.last_vertex;
      if (cnt_q == '0) begin
        first_x_q <= vertex_i.vertex_x[CoordW-1:0];
        first_y_q <= vertex_i.vertex_y[CoordW-1:0];
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= mul_p;
      case (step_q)
        3'd1:    sq_q   <= SqW'(prod_q);
        3'd2:    sq_q   <= sq_q + SqW'(prod_q);
        3'd3:    term_q <= prod_q;
        3'd4:    term_q <= term_q - prod_q;
        default: sq_q   <= sq_q;
      endcase
    end
    if ((state_q == ST_EMIT) && out_free) begin
      area_q  <= area_sat ? '1 : mag[AreaW:1];
      perim_q <= len_q;
      total_q <= TotalW'(cnt_q);
      oflag_q <= ovf_q | area_sat;
    end
  end

  assign vertex_i.ready             = (state_q == ST_IDLE);
  assign result_o.valid             = out_valid_q;
  assign result_o.polygon_area      = area_q;
  assign result_o.polygon_perimeter = perim_q;
  assign result_o.vertex_total      = total_q;
  assign result_o.overflow_flag     = oflag_q;

endmodule

// ===== rtl/apa_isqrt.sv =====
// ----------------------------------------------------------------------------
// apa_isqrt
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module apa_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [apa_pkg::SqW-1:0]     radicand_i,
  output logic                        done_o,
  output logic [apa_pkg::RootW-1:0]   root_o
);
  import apa_pkg::*;

  localparam int unsigned RemW  = RootW + 4;
  localparam int unsigned StepW = $clog2(RootW);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [SqW-1:0]   rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;

  logic [RemW-1:0]  rem_cat;
  logic [RemW-1:0]  trial;
  logic             fits;

  // Bring down the next two radicand bits and try root*4+1
  assign rem_cat = {rem_q[RemW-3:0], rad_q[SqW-1 -: 2]};
  assign trial   = RemW'({root_q, 2'b01});
  assign fits    = (rem_cat >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      // Flag the cycle after the last root bit resolves
      done_q <= busy_q && !start_i && (step_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(RootW - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SqW-3:0], 2'b00};
      rem_q  <= fits ? (rem_cat - trial) : rem_cat;
      root_q <= {root_q[RootW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== bench/tb_polygon_area_perimeter_stream.sv =====
// ----------------------------------------------------------------------------
// tb_polygon_area_perimeter_stream
// Self-checking bench for the shoelace area and perimeter stream. A short
// table of hand-picked polygons comes first, then one long winding polygon
// that drives the vertex count and the area into saturation, then random
// polygons. Results are checked against a table value or a shoelace predictor.
// ----------------------------------------------------------------------------
module tb_polygon_area_perimeter_stream;
  timeunit 1ns;
  timeprecision 1ps;
  import apa_pkg::*;

  localparam int unsigned MaxVertices = DefMaxVertices;
  localparam longint CrossHi = 64'sd4398046511103;
  localparam longint CrossLo = -CrossHi - 1;
  localparam longint LenHi = 64'sd134217727;
  localparam longint AreaHi = 64'sd1099511627775;
  localparam int PlanItems = 1550;
  localparam int QuietFrom = 6000;
  localparam int QuietTo = 18000;
  localparam int DrainCycles = 64;
  localparam logic signed [CoordInW-1:0] CMin = 16'sh8000;
  localparam logic signed [CoordInW-1:0] CMax = 16'sh7fff;

  typedef struct packed {
    logic [AreaW-1:0]  area;
    logic [LenW-1:0]   perim;
    logic [TotalW-1:0] total;
    logic              ovf;
  } poly_result_t;

  typedef struct packed {
    logic signed [CoordInW-1:0] x;
    logic signed [CoordInW-1:0] y;
    logic                       last;
    logic                       typed;  // want holds a hand-computed result
    poly_result_t               want;
  } vertex_req_t;

  localparam int DirectedN = 23;
  localparam vertex_req_t DirectedRows [DirectedN] = '{
    // lone vertex at the origin, then at opposite extremes
    '{16'sd0, 16'sd0, 1'b1, 1'b1, '{40'd0, 27'd0, 11'd1, 1'b0}},
    '{CMin, CMax, 1'b1, 1'b1, '{40'd0, 27'd0, 11'd1, 1'b0}},
    // full-range square, counterclockwise
    '{CMin, CMin, 1'b0, 1'b0, '0},
    '{CMax, CMin, 1'b0, 1'b0, '0},
    '{CMax, CMax, 1'b0, 1'b0, '0},
    '{CMin, CMax, 1'b1, 1'b1, '{40'd4294836225, 27'd262140, 11'd4, 1'b0}},
    // flat back-and-forth segment
    '{16'sd256, 16'sd0, 1'b0, 1'b0, '0},
    '{-16'sd256, 16'sd0, 1'b1, 1'b1, '{40'd0, 27'd1024, 11'd2, 1'b0}},
    // right triangle with a diagonal edge
    '{16'sd0, 16'sd0, 1'b0, 1'b0, '0},
    '{16'sd256, 16'sd0, 1'b0, 1'b0, '0},
    '{16'sd0, 16'sd256, 1'b1, 1'b1, '{40'd32768, 27'd874, 11'd3, 1'b0}},
    // clockwise square, negative cross sum
    '{-16'sd256, -16'sd256, 1'b0, 1'b0, '0},
    '{-16'sd256, 16'sd256, 1'b0, 1'b0, '0},
    '{16'sd256, 16'sd256, 1'b0, 1'b0, '0},
    '{16'sd256, -16'sd256, 1'b1, 1'b1, '{40'd262144, 27'd2048, 11'd4, 1'b0}},
    // longest possible edge, corner to corner
    '{CMin, CMin, 1'b0, 1'b0, '0},
    '{CMax, CMax, 1'b1, 1'b0, '0},
    // mixed-sign triangle
    '{CMin, CMax, 1'b0, 1'b0, '0},
    '{CMax, CMin, 1'b0, 1'b0, '0},
    '{16'sd12345, -16'sd9876, 1'b1, 1'b0, '0},
    // odd cross sum, area rounds down
    '{16'sd0, 16'sd0, 1'b0, 1'b0, '0},
    '{16'sd3, 16'sd0, 1'b0, 1'b0, '0},
    '{16'sd0, 16'sd1, 1'b1, 1'b1, '{40'd1, 27'd7, 11'd3, 1'b0}}
  };

  logic clk;
  logic rst_n;

  apa_vertex_if vertex_bus ();
  apa_result_if result_bus ();

  polygon_area_perimeter_stream dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .vertex_i (vertex_bus),
    .result_o (result_bus)
  );

  // Predictor state: one polygon in progress
  logic signed [CoordInW-1:0] anchor_x, anchor_y, trail_x, trail_y;
  logic signed [CrossW-1:0]   cross_acc;
  logic [LenW-1:0]            length_acc;
  logic [TotalW-1:0]          vertices_seen;
  logic                       sat_seen;

  vertex_req_t  vertex_plan[$];
  poly_result_t pending_results[$];
  int plan_idx;
  int cycle_count;
  int cycle_limit;
  int fail_count;
  int results_seen;
  int flagged_seen;
  int polygons_planned;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void add_to_plan(vertex_req_t req);
    vertex_plan.insert(vertex_plan.size(), req);
  endfunction

  function automatic void add_expected(poly_result_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  function automatic longint edge_length(longint sq);
    longint root;
    longint trial;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'sd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return root;
  endfunction

  function automatic void add_edge_to_sums(logic signed [CoordInW-1:0] ax,
                                           logic signed [CoordInW-1:0] ay,
                                           logic signed [CoordInW-1:0] bx,
                                           logic signed [CoordInW-1:0] by);
    longint dx, dy, acc, len;
    dx = longint'(bx) - longint'(ax);
    dy = longint'(by) - longint'(ay);
    acc = longint'(cross_acc) + longint'(ax) * longint'(by) - longint'(bx) * longint'(ay);
    if (acc > CrossHi) begin
      acc = CrossHi;
      sat_seen = 1'b1;
    end
    if (acc < CrossLo) begin
      acc = CrossLo;
      sat_seen = 1'b1;
    end
    cross_acc = acc[CrossW-1:0];
    len = longint'(length_acc) + edge_length(dx * dx + dy * dy);
    if (len > LenHi) begin
      len = LenHi;
      sat_seen = 1'b1;
    end
    length_acc = len[LenW-1:0];
  endfunction

  function automatic void clear_polygon();
    anchor_x = '0;
    anchor_y = '0;
    trail_x = '0;
    trail_y = '0;
    cross_acc = '0;
    length_acc = '0;
    vertices_seen = '0;
    sat_seen = 1'b0;
  endfunction

  // Fold one accepted vertex into the running sums; queue a result on the last
  function automatic void fold_vertex(vertex_req_t req);
    longint mag, area;
    poly_result_t guess;
    if (vertices_seen == 0) begin
      anchor_x = req.x;
      anchor_y = req.y;
    end else begin
      add_edge_to_sums(trail_x, trail_y, req.x, req.y);
    end
    trail_x = req.x;
    trail_y = req.y;
    if (vertices_seen >= MaxVertices) begin
      vertices_seen = TotalW'(MaxVertices);
      sat_seen = 1'b1;
    end else begin
      vertices_seen++;
    end
    if (req.last) begin
      add_edge_to_sums(req.x, req.y, anchor_x, anchor_y);
      mag = (cross_acc < 0) ? -longint'(cross_acc) : longint'(cross_acc);
      area = mag >> 1;
      guess.ovf = sat_seen;
      if (area > AreaHi) begin
        area = AreaHi;
        guess.ovf = 1'b1;
      end
      guess.area = area[AreaW-1:0];
      guess.perim = length_acc;
      guess.total = vertices_seen;
      add_expected(req.typed ? req.want : guess);
      clear_polygon();
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic check_result(poly_result_t got);
    poly_result_t want;
    results_seen++;
    if (got.ovf) flagged_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = pending_results.pop_front();
      if (got.area !== want.area)
        report_mismatch($sformatf("result %0d area %0d, want %0d",
                                  results_seen, got.area, want.area));
      if (got.perim !== want.perim)
        report_mismatch($sformatf("result %0d perimeter %0d, want %0d",
                                  results_seen, got.perim, want.perim));
      if (got.total !== want.total)
        report_mismatch($sformatf("result %0d vertex_total %0d, want %0d",
                                  results_seen, got.total, want.total));
      if (got.ovf !== want.ovf)
        report_mismatch($sformatf("result %0d overflow_flag %0b, want %0b",
                                  results_seen, got.ovf, want.ovf));
    end
  endtask

  function automatic bit idle_now();
    if (cycle_count >= QuietFrom && cycle_count < QuietTo) return 1'b0;
    return $urandom_range(99) < 11;
  endfunction

  function automatic logic signed [CoordInW-1:0] pick_coord(int mode);
    case (mode)
      1: return CoordInW'($urandom_range(1200) - 600);
      2: begin
        case ($urandom_range(4))
          0: return CMin;
          1: return CMax;
          2: return '0;
          3: return '1;
          default: return CoordInW'($urandom);
        endcase
      end
      default: return CoordInW'($urandom);
    endcase
  endfunction

  task automatic plan_polygon(int n, int mode);
    vertex_req_t req;
    for (int k = 0; k < n; k++) begin
      req = '0;
      req.x = pick_coord(mode);
      req.y = pick_coord(mode);
      req.last = (k == n - 1);
      add_to_plan(req);
    end
    polygons_planned++;
  endtask

  // Circle the four corners over and over so every sum keeps growing
  task automatic plan_winding(int n, bit clockwise);
    vertex_req_t req;
    int corner;
    for (int k = 0; k < n; k++) begin
      req = '0;
      corner = clockwise ? 3 - (k % 4) : k % 4;
      req.x = (corner == 1 || corner == 2) ? CMax - CoordInW'($urandom_range(255))
                                           : CMin + CoordInW'($urandom_range(255));
      req.y = (corner >= 2) ? CMax - CoordInW'($urandom_range(255))
                            : CMin + CoordInW'($urandom_range(255));
      req.last = (k == n - 1);
      add_to_plan(req);
    end
    polygons_planned++;
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 1;
    if (r < 20) return 2;
    if (r < 75) return $urandom_range(8, 3);
    if (r < 95) return $urandom_range(40, 9);
    return $urandom_range(200, 41);
  endfunction

  // Drive requests, take results and advance the predictor on each handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      vertex_bus.valid <= 1'b0;
      vertex_bus.vertex_x <= '0;
      vertex_bus.vertex_y <= '0;
      vertex_bus.last_vertex <= 1'b0;
      result_bus.ready <= 1'b0;
    end else begin
      if (vertex_bus.valid && vertex_bus.ready) begin
        fold_vertex(vertex_plan[plan_idx]);
        plan_idx++;
      end
      if (!vertex_bus.valid || vertex_bus.ready) begin
        if (plan_idx < vertex_plan.size() && !idle_now()) begin
          vertex_bus.valid <= 1'b1;
          vertex_bus.vertex_x <= vertex_plan[plan_idx].x;
          vertex_bus.vertex_y <= vertex_plan[plan_idx].y;
          vertex_bus.last_vertex <= vertex_plan[plan_idx].last;
        end else begin
          vertex_bus.valid <= 1'b0;
        end
      end
      if (result_bus.valid && result_bus.ready)
        check_result(poly_result_t'{result_bus.polygon_area, result_bus.polygon_perimeter,
                                    result_bus.vertex_total, result_bus.overflow_flag});
      result_bus.ready <= !idle_now();
      cycle_count++;
      if (cycle_count == cycle_limit) begin
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, pending_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int size;
    rst_n = 1'b0;
    plan_idx = 0;
    cycle_count = 0;
    fail_count = 0;
    results_seen = 0;
    flagged_seen = 0;
    polygons_planned = 0;
    clear_polygon();

    foreach (DirectedRows[i]) begin
      add_to_plan(DirectedRows[i]);
      if (DirectedRows[i].last) polygons_planned++;
    end
    plan_winding(1080 + $urandom_range(40), bit'($urandom_range(1)));
    while (vertex_plan.size() < PlanItems) begin
      size = pick_size();
      plan_polygon(size, $urandom_range(3));
    end
    cycle_limit = vertex_plan.size() * 200 + 20000;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (plan_idx < vertex_plan.size()) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d vertices in %0d polygons; %0d results checked, %0d with overflow set.",
             vertex_plan.size(), polygons_planned, results_seen, flagged_seen);
    $display("One long winding polygon pushed the vertex count and area into saturation.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
